/* rtl/md5_pkg.sv */
package md5_pkg;

  localparam int MSG_WORDS   = 16;
  localparam int MSG_AW      = $clog2(MSG_WORDS);
  localparam int STEPS       = 64;
  localparam int STEP_W      = $clog2(STEPS);
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int DIGEST_WORDS = 4;

  // Fetch skew: the RAM read register, then the word-plus-constant register.
  localparam int RUN_SKEW   = 2;
  localparam int RUN_CYCLES = STEPS + RUN_SKEW;
  localparam int RUN_CNT_W  = $clog2(RUN_CYCLES);

  // Standard initial value, index 0 is A.
  localparam logic [DIGEST_WORDS-1:0][31:0] INIT_VALUE = {
    32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  typedef struct packed {
    logic [31:0]       word;
    logic [MSG_AW-1:0] index;
    logic              first;
    logic              last;
  } word_req_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_FINISH,
    BK_EMIT
  } back_state_t;

  // Message word used by each step.
  function automatic logic [MSG_AW-1:0] msg_index(input logic [STEP_W-1:0] step);
    logic [MSG_AW-1:0] low;
    logic [MSG_AW-1:0] idx;
    low = step[MSG_AW-1:0];
    case (step[STEP_W-1:STEP_W-2])
      2'd0:    idx = low;
      2'd1:    idx = MSG_AW'(low * 4'd5 + 4'd1);
      2'd2:    idx = MSG_AW'(low * 4'd3 + 4'd5);
      default: idx = MSG_AW'(low * 4'd7);
    endcase
    return idx;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [3:0] sel);
    logic [4:0] amt;
    case (sel)
      4'd0:    amt = 5'd7;
      4'd1:    amt = 5'd12;
      4'd2:    amt = 5'd17;
      4'd3:    amt = 5'd22;
      4'd4:    amt = 5'd5;
      4'd5:    amt = 5'd9;
      4'd6:    amt = 5'd14;
      4'd7:    amt = 5'd20;
      4'd8:    amt = 5'd4;
      4'd9:    amt = 5'd11;
      4'd10:   amt = 5'd16;
      4'd11:   amt = 5'd23;
      4'd12:   amt = 5'd6;
      4'd13:   amt = 5'd10;
      4'd14:   amt = 5'd15;
      default: amt = 5'd21;
    endcase
    return amt;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] dbl;
    dbl = {v, v} << s;
    return dbl[63:32];
  endfunction

  function automatic logic [31:0] sine_constant(input logic [STEP_W-1:0] step);
    logic [31:0] k;
    case (step)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

endpackage

/* rtl/md5_ram.sv */
module md5_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/md5_front.sv */
module md5_front import md5_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        word_valid,
  output logic        word_ready,
  input  logic [31:0] message_word,
  input  logic        first_block,
  input  logic        last_block,
  output logic        push_valid,
  input  logic        push_ready,
  output word_req_t   push_req
);

  logic [MSG_AW-1:0] word_count;

  assign word_ready = push_ready;
  assign push_valid = word_valid;

  // Tag each word with its place in the block; flags only matter on the final word.
  always_comb begin
    push_req.word  = message_word;
    push_req.index = word_count;
    push_req.first = first_block;
    push_req.last  = last_block;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_count <= '0;
    end else if (word_valid && push_ready) begin
      word_count <= word_count + MSG_AW'(1);
    end
  end

endmodule

/* rtl/md5_queue.sv */
module md5_queue import md5_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  output logic      push_ready,
  input  word_req_t push_req,
  output logic      pop_valid,
  input  logic      pop_ready,
  output word_req_t pop_req
);

  word_req_t            entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  head;
  logic [QUEUE_AW-1:0]  tail;
  logic [QUEUE_AW:0]    fill;
  logic                 push;
  logic                 pop;

  assign push_ready = fill != (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_req    = entries[head];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        tail <= tail + QUEUE_AW'(1);
      end
      if (pop) begin
        head <= head + QUEUE_AW'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + (QUEUE_AW+1)'(1);
        2'b01:   fill <= fill - (QUEUE_AW+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* rtl/md5_back.sv */
module md5_back import md5_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_ready,
  input  word_req_t   q_req,
  output logic        digest_valid,
  input  logic        digest_ready,
  output logic [31:0] digest_word,
  output logic [1:0]  word_number,
  output logic        last
);

  back_state_t state;
  back_state_t state_next;

  logic [DIGEST_WORDS-1:0][31:0] cv;
  logic [31:0]          a, b, c, d;
  logic [31:0]          wk;
  logic                 blk_first;
  logic                 blk_last;
  logic [RUN_CNT_W-1:0] cnt;
  logic [1:0]           emit_cnt;
  logic                 pop;
  logic                 block_end;
  logic                 load_out;

  logic [31:0]          rdata;
  logic [MSG_AW-1:0]    raddr;
  logic [STEP_W-1:0]    step_idx;
  logic [1:0]           round;
  logic [31:0]          f;
  logic [31:0]          sum;
  logic [31:0]          b_new;
  logic                 step_en;

  md5_ram #(.WIDTH(32), .DEPTH(MSG_WORDS)) u_msg_ram (
    .clk   (clk),
    .we    (pop),
    .waddr (q_req.index),
    .wdata (q_req.word),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign block_end = q_req.index == MSG_AW'(MSG_WORDS - 1);
  assign q_ready   = pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    case (state)
      BK_IDLE: begin
        pop = q_valid;
        if (q_valid && block_end) begin
          state_next = BK_RUN;
        end
      end
      BK_RUN: begin
        if (cnt == RUN_CNT_W'(RUN_CYCLES - 1)) begin
          state_next = BK_FINISH;
        end
      end
      BK_FINISH: begin
        state_next = blk_last ? BK_EMIT : BK_IDLE;
      end
      BK_EMIT: begin
        load_out = !digest_valid || digest_ready;
        if (load_out && emit_cnt == 2'(DIGEST_WORDS - 1)) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Read for step cnt, add constant for step cnt-1, execute step cnt-2.
  assign raddr    = msg_index(cnt[STEP_W-1:0]);
  assign step_idx = cnt[STEP_W-1:0] - STEP_W'(RUN_SKEW);
  assign round    = step_idx[STEP_W-1:STEP_W-2];
  assign step_en  = (state == BK_RUN) && (cnt >= RUN_CNT_W'(RUN_SKEW));

  always_comb begin
    case (round)
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (b & d) | (c & ~d);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    sum   = a + f + wk;
    b_new = b + rotl32(sum, rot_amount({round, step_idx[1:0]}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv       <= INIT_VALUE;
      cnt      <= '0;
      emit_cnt <= '0;
      digest_valid <= 1'b0;
    end else begin
      if (pop && block_end) begin
        cnt <= '0;
      end else if (state == BK_RUN) begin
        cnt <= cnt + RUN_CNT_W'(1);
      end
      if (state == BK_FINISH) begin
        emit_cnt <= '0;
        for (int k = 0; k < DIGEST_WORDS; k++) begin
          cv[k] <= (blk_first ? INIT_VALUE[k] : cv[k]) +
                   (k == 0 ? a : k == 1 ? b : k == 2 ? c : d);
        end
      end
      if (load_out) begin
        digest_valid <= 1'b1;
        emit_cnt     <= emit_cnt + 2'd1;
      end else if (digest_ready) begin
        digest_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && block_end) begin
      blk_first <= q_req.first;
      blk_last  <= q_req.last;
      a <= q_req.first ? INIT_VALUE[0] : cv[0];
      b <= q_req.first ? INIT_VALUE[1] : cv[1];
      c <= q_req.first ? INIT_VALUE[2] : cv[2];
      d <= q_req.first ? INIT_VALUE[3] : cv[3];
    end else if (step_en) begin
      a <= d;
      b <= b_new;
      c <= b;
      d <= c;
    end
    if (state == BK_RUN) begin
      wk <= rdata + sine_constant(cnt[STEP_W-1:0] - STEP_W'(1));
    end
    if (load_out) begin
      digest_word <= cv[emit_cnt];
      word_number <= emit_cnt;
      last        <= emit_cnt == 2'(DIGEST_WORDS - 1);
    end
  end

endmodule

/* rtl/md5_block_compression_unit.sv */
// MD5 block compression unit.
//
// Input channel (word_valid / word_ready): one 32-bit little-endian message
// word per request, already padded, 16 requests to a 512-bit block. The
// first_block and last_block flags are sampled on the sixteenth word only:
// first_block starts the block from the standard initial value, last_block
// makes the unit emit the digest after that block.
// Output channel (digest_valid / digest_ready): four requests, A to D, with
// word_number 0..3 and last set on D. Blocks without last_block emit nothing.
//
// A front stage tags words with their block position and pushes them into a
// four-entry queue; the back end drains the queue into a 16-word message RAM
// and runs one MD5 step per cycle through a single step unit. A block passes
// through a drain of its 16 words, the 64 steps behind the RAM fetch skew,
// one chaining-value update and, for a final block, the emission of four
// digest words. The back end takes no words from the queue until it is idle
// again; the first digest word is registered after the chaining-value update.
// Reset clears the queue and the word counter and loads the initial value.
// When the receiver stalls, the output register holds its word; the queue
// keeps taking words until it fills, then word_ready drops.
module md5_block_compression_unit import md5_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        word_valid,
  output logic        word_ready,
  input  logic [31:0] message_word,
  input  logic        first_block,
  input  logic        last_block,
  output logic        digest_valid,
  input  logic        digest_ready,
  output logic [31:0] digest_word,
  output logic [1:0]  word_number,
  output logic        last
);

  logic      push_valid;
  logic      push_ready;
  word_req_t push_req;
  logic      q_valid;
  logic      q_ready;
  word_req_t q_req;

  // Classify: count words within the block.
  md5_front u_front (
    .clk          (clk),
    .rst          (rst),
    .word_valid   (word_valid),
    .word_ready   (word_ready),
    .message_word (message_word),
    .first_block  (first_block),
    .last_block   (last_block),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_req     (push_req)
  );

  // Decouple: let the front keep accepting while the back compresses or stalls.
  md5_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_req   (push_req),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_req    (q_req)
  );

  // Store, compress, accumulate and emit.
  md5_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_req        (q_req),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready),
    .digest_word  (digest_word),
    .word_number  (word_number),
    .last         (last)
  );

endmodule

/* rtl/md5_checker.sv */
module md5_checker (
  input logic        clk,
  input logic        rst,
  input logic        word_ready,
  input logic        digest_valid,
  input logic        digest_ready,
  input logic [31:0] digest_word,
  input logic [1:0]  word_number,
  input logic        last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    digest_valid && !digest_ready |=> digest_valid && $stable(digest_word)
      && $stable(word_number))
    else $error("digest request changed while stalled");

  a_last_d: assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> (last == (word_number == 2'd3)))
    else $error("last flag does not match word D");

  a_sequence: assert property (@(posedge clk) disable iff (rst)
    digest_valid && digest_ready && !last |=> digest_valid
      && word_number == $past(word_number) + 2'd1)
    else $error("digest words not back to back in order");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !digest_valid && word_ready)
    else $error("unit not empty after reset");

endmodule

bind md5_block_compression_unit md5_checker u_md5_checker (
  .clk          (clk),
  .rst          (rst),
  .word_ready   (word_ready),
  .digest_valid (digest_valid),
  .digest_ready (digest_ready),
  .digest_word  (digest_word),
  .word_number  (word_number),
  .last         (last)
);

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;

  // Cycle budget for the whole run. The slow case is about 35 blocks, with
  // every request behind a long sender gap and every digest word behind a
  // long receiver stall. This limit is several times that.
  localparam int CYCLE_LIMIT = 400000;
  // Cycles to let the unit settle after the last expected digest word. This
  // covers a block without last_block that is still compressing, from its
  // sixteenth word to the end of its steps.
  localparam int SETTLE_CYCLES = 120;
  localparam int RANDOM_WORDS = 384;

  // MD5 initial chaining value, A first.
  localparam logic [0:3][31:0] MD5_IV = {
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  // Additive constants, one for each of the 64 steps.
  localparam logic [0:63][31:0] STEP_K = {
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Rotate amounts: four per round, cycled through by the steps of a round.
  localparam logic [0:15][4:0] STEP_ROT = {
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  number;
    logic        fin;
  } digest_entry_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        word_valid = 1'b0;
  logic        word_ready;
  logic [31:0] message_word = '0;
  logic        first_block = 1'b0;
  logic        last_block = 1'b0;
  logic        digest_valid;
  logic        digest_ready = 1'b0;
  logic [31:0] digest_word;
  logic [1:0]  word_number;
  logic        last;

  // Shadow of the unit: block buffer, fill position and chaining value.
  logic [0:15][31:0] block_words;
  logic [3:0]        block_fill;
  logic [0:3][31:0]  chain_value;

  digest_entry_t digest_expected[$];

  int error_count = 0;
  int cycle_count = 0;
  int words_sent = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int stall_phase = 0;

  md5_block_compression_unit uut (
    .clk          (clk),
    .rst          (rst),
    .word_valid   (word_valid),
    .word_ready   (word_ready),
    .message_word (message_word),
    .first_block  (first_block),
    .last_block   (last_block),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready),
    .digest_word  (digest_word),
    .word_number  (word_number),
    .last         (last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop: a hang anywhere counts as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  // Run the 64 MD5 steps over the buffered block and fold the working words
  // into the chaining value. Start from the initial value on a first block.
  task automatic compress_block(input logic from_iv);
    logic [0:3][31:0] seed;
    logic [31:0] a, b, c, d, f, sum, tmp;
    int rnd, g, sh;
    seed = from_iv ? MD5_IV : chain_value;
    a = seed[0];
    b = seed[1];
    c = seed[2];
    d = seed[3];
    for (int i = 0; i < 64; i++) begin
      rnd = i >> 4;
      case (rnd)
        0: begin
          f = (b & c) | (~b & d);
          g = i;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = 5 * i + 1;
        end
        2: begin
          f = b ^ c ^ d;
          g = 3 * i + 5;
        end
        default: begin
          f = c ^ (b | ~d);
          g = 7 * i;
        end
      endcase
      sum = a + f + block_words[g % 16] + STEP_K[i];
      sh = STEP_ROT[rnd * 4 + i % 4];
      tmp = d;
      d = c;
      c = b;
      b = b + ((sum << sh) | (sum >> (32 - sh)));
      a = tmp;
    end
    chain_value[0] = seed[0] + a;
    chain_value[1] = seed[1] + b;
    chain_value[2] = seed[2] + c;
    chain_value[3] = seed[3] + d;
  endtask

  // Take one accepted request into the shadow; on the sixteenth word of a
  // block compress, and on a final block queue the four digest words.
  task automatic absorb_word(input logic [31:0] w, input logic fb, input logic lb);
    digest_entry_t e;
    block_words[block_fill] = w;
    if (block_fill != 4'd15) begin
      block_fill = block_fill + 4'd1;
    end else begin
      block_fill = 4'd0;
      compress_block(fb);
      if (lb) begin
        for (int k = 0; k < 4; k++) begin
          e.word = chain_value[k];
          e.number = 2'(k);
          e.fin = (k == 3);
          digest_expected.push_back(e);
        end
      end
    end
  endtask

  // Send one request. Start a new burst when the old one is used up, and
  // drop valid for the gap in front of it, if any.
  task automatic send_word(input logic [31:0] w, input logic fb, input logic lb);
    int gap, pick;
    if (burst_left == 0) begin
      pick = $urandom_range(0, 9);
      burst_left = (pick == 0) ? 64 : $urandom_range(1, 20);
      pick = $urandom_range(0, 9);
      if (pick < 3) gap = 0;
      else if (pick < 8) gap = $urandom_range(1, 6);
      else gap = $urandom_range(20, 90);
      if (gap > 0) begin
        word_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    word_valid <= 1'b1;
    message_word <= w;
    first_block <= fb;
    last_block <= lb;
    // Hold the request until it is taken.
    do @(posedge clk); while (!word_ready);
    absorb_word(w, fb, lb);
    words_sent++;
    burst_left--;
  endtask

  // Send a whole 16-word block. The flags count on the sixteenth word only;
  // with noise set, the other fifteen carry random flags.
  task automatic send_block(input logic [15:0][31:0] words, input logic fb,
                            input logic lb, input bit noise);
    for (int i = 0; i < 16; i++) begin
      if (i == 15) send_word(words[i], fb, lb);
      else if (noise) send_word(words[i], 1'($urandom), 1'($urandom));
      else send_word(words[i], 1'b0, 1'b0);
    end
  endtask

  // Drop valid, wait for every expected digest word, then let a block that
  // emits nothing finish its steps.
  task automatic wait_idle();
    word_valid <= 1'b0;
    burst_left = 0;
    while (digest_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Check each digest request against the oldest expectation, and drive the
  // receiver stall pattern: always ready, coin flips, a short duty cycle, or
  // a long stall.
  always @(posedge clk) begin
    digest_entry_t e;
    if (rst) begin
      digest_ready <= 1'b0;
    end else begin
      if (digest_valid && digest_ready) begin
        if (digest_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected digest word %08h number %0d",
                                    digest_word, word_number));
        end else begin
          e = digest_expected.pop_front();
          if (digest_word !== e.word)
            report_mismatch($sformatf("digest_word %08h, expected %08h (number %0d)",
                                      digest_word, e.word, e.number));
          if (word_number !== e.number)
            report_mismatch($sformatf("word_number %0d, expected %0d",
                                      word_number, e.number));
          if (last !== e.fin)
            report_mismatch($sformatf("last %b, expected %b (number %0d)",
                                      last, e.fin, e.number));
        end
      end
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_left <= $urandom_range(8, 60);
        stall_phase <= 0;
        digest_ready <= 1'b1;
      end else begin
        stall_left <= stall_left - 1;
        stall_phase <= stall_phase + 1;
        case (stall_mode)
          0: digest_ready <= 1'b1;
          1: digest_ready <= 1'($urandom);
          2: digest_ready <= (stall_phase % 7) < 2;
          default: digest_ready <= (stall_left < 3);
        endcase
      end
    end
  end

  // One-block message "abc", padded: the textbook case, first and last set.
  task automatic test_single_block();
    logic [15:0][31:0] w;
    w = '0;
    w[0] = 32'h80636261;
    w[14] = 32'h00000018;
    send_block(w, 1'b1, 1'b1, 1'b0);
    wait_idle();
  endtask

  // A first block without last_block emits nothing; the next block chains
  // from it. Field extremes: all-zero words, then all-one words.
  task automatic test_chain_without_last();
    send_block('0, 1'b1, 1'b0, 1'b0);
    send_block('1, 1'b0, 1'b1, 1'b0);
    wait_idle();
  endtask

  // After a digest, a block without first_block chains from the final sums.
  // Flags on the first fifteen words are noise and must be ignored.
  task automatic test_flags_ignored();
    logic [15:0][31:0] w;
    for (int i = 0; i < 16; i++) w[i] = 32'h1 << (2 * i);
    send_block(w, 1'b0, 1'b1, 1'b1);
    for (int i = 0; i < 16; i++) w[i] = ~(32'h1 << (2 * i + 1));
    send_block(w, 1'b1, 1'b0, 1'b1);
    send_block(w, 1'b0, 1'b1, 1'b1);
    wait_idle();
  endtask

  // Random messages of one to four blocks. Most start with first_block;
  // some chain on from the last digest, and some have flags thrown at
  // random on the closing word.
  task automatic test_random_messages();
    logic [15:0][31:0] w;
    int start_count, nblk, kind;
    logic fresh, fb, lb;
    start_count = words_sent;
    while (words_sent - start_count < RANDOM_WORDS) begin
      nblk = ($urandom_range(0, 9) == 0) ? 4 : $urandom_range(1, 3);
      fresh = ($urandom_range(0, 99) < 85);
      for (int bk = 0; bk < nblk; bk++) begin
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 16; i++) begin
          case (kind)
            0: w[i] = '0;
            1: w[i] = '1;
            2: w[i] = 32'h1 << $urandom_range(0, 31);
            default: w[i] = $urandom;
          endcase
        end
        fb = (bk == 0) ? fresh : 1'b0;
        lb = (bk == nblk - 1);
        if ($urandom_range(0, 9) == 0) begin
          fb = 1'($urandom);
          lb = 1'($urandom);
        end
        send_block(w, fb, lb, $urandom_range(0, 3) == 0);
      end
    end
    wait_idle();
  endtask

  initial begin
    block_words = '0;
    block_fill = 4'd0;
    chain_value = MD5_IV;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_block();
    test_chain_without_last();
    test_flags_ignored();
    test_random_messages();
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
